// File: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue: channel words,
// command broadcast to the cell row, and the link between neighbor cells.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  // default number of slots; the queue holds one fewer value
  localparam int SLOTS_DEF = 16;

  localparam int VAL_W   = 32;
  localparam int CNT_OUT_W = 4;

  // command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // input word
  typedef struct packed {
    logic                    command;
    logic signed [VAL_W-1:0] value;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] removed_value;
    logic [CNT_OUT_W-1:0]    held_count;
  } out_word_t;

  // broadcast to every cell
  typedef struct packed {
    logic                    insert_en;
    logic                    remove_en;
    logic signed [VAL_W-1:0] value;
  } spq_cmd_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic                    valid;
    logic                    open;   // empty or holds a value above the new one
    logic signed [VAL_W-1:0] value;
  } spq_link_t;

endpackage

`default_nettype wire

// File: rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Keeps up to SLOTS-1 signed values in ascending order in a row of cells;
// an insert lands after all equal values, a remove takes the smallest.
// ----------------------------------------------------------------------------
// the result word for an accepted input word is in the output reg in the next cycle
// throughput: one word per cycle while in_stall is low, every cell compares and shifts in parallel
// the output register is freed when its word is taken, so stalls only
//   back up while a result waits and the downstream side holds stall
// reset clears all cell valid bits, the count and the output valid
`default_nettype none

module sorted_priority_queue #(
  parameter int SLOTS = spq_pkg::SLOTS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire spq_pkg::in_word_t in_word,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output spq_pkg::out_word_t    out_word
);
  import spq_pkg::*;

  localparam int NCELL = SLOTS - 1;
  localparam int CNT_W = $clog2(SLOTS);

  spq_link_t               links [NCELL];
  spq_link_t               lefts [NCELL];
  spq_link_t               rights[NCELL];
  spq_cmd_t                cmd;
  logic                    accept;
  logic                    full, empty;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;
  logic                    out_valid_r;
  out_word_t               out_word_r, out_word_nxt;

  // handshake
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign full  = links[NCELL-1].valid;
  assign empty = !links[0].valid;

  // command broadcast
  assign cmd.insert_en = accept && (in_word.command == CMD_INSERT) && !full;
  assign cmd.remove_en = accept && (in_word.command == CMD_REMOVE) && !empty;
  assign cmd.value     = in_word.value;

  // cell row with its neighbor links
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign lefts[i] = '{valid: 1'b1, open: 1'b0, value: '0};
    end else begin : g_mid_l
      assign lefts[i] = links[i-1];
    end
    if (i == NCELL-1) begin : g_last
      assign rights[i] = '{valid: 1'b0, open: 1'b1, value: '0};
    end else begin : g_mid_r
      assign rights[i] = links[i+1];
    end
    spq_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (cmd),
      .left  (lefts[i]),
      .right (rights[i]),
      .self  (links[i])
    );
  end

  // held count
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.insert_en) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.remove_en) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  assign cnt_ext = {{CNT_OUT_W{1'b0}}, cnt_nxt};

  // result word
  always_comb begin
    out_word_nxt.status        = ST_OK;
    out_word_nxt.removed_value = '0;
    out_word_nxt.held_count    = cnt_ext[CNT_OUT_W-1:0];
    if (in_word.command == CMD_INSERT) begin
      if (full) begin
        out_word_nxt.status = ST_FULL;
      end
    end else begin
      if (empty) begin
        out_word_nxt.status = ST_EMPTY;
      end else begin
        out_word_nxt.removed_value = links[0].value;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (accept) begin
      out_word_r <= out_word_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One position of the sorted row. Compares its value against the broadcast
// value, and on an insert either keeps, takes the new value or takes the
// left neighbor's value; on a remove takes the right neighbor's value.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire spq_pkg::spq_cmd_t  cmd,
  input  wire spq_pkg::spq_link_t left,
  input  wire spq_pkg::spq_link_t right,
  output spq_pkg::spq_link_t      self
);
  import spq_pkg::*;

  logic                    valid_r, valid_nxt;
  logic signed [VAL_W-1:0] value_r, value_nxt;
  logic                    open;

  // strictly greater keeps equal values in arrival order
  assign open = !valid_r || (value_r > cmd.value);

  assign self.valid = valid_r;
  assign self.open  = open;
  assign self.value = value_r;

  // next content of the cell
  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    if (cmd.insert_en) begin
      if (open) begin
        valid_nxt = valid_r | left.valid;
        value_nxt = left.open ? left.value : cmd.value;
      end
    end else if (cmd.remove_en) begin
      valid_nxt = right.valid;
      value_nxt = right.value;
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // held value, no reset
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

`default_nettype wire
